[rtl/voxel_hit_histogram_unit_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef VOXEL_HIT_HISTOGRAM_UNIT_MACROS_SVH
`define VOXEL_HIT_HISTOGRAM_UNIT_MACROS_SVH

// implication checked every clock, idle in reset
`define VHH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the next clock
`define VHH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/vhh_pkg.sv]
// constants of the voxel hit histogram
// no dependencies
package vhh_pkg;
    localparam logic [2:0] OP_HIT       = 3'd0;
    localparam logic [2:0] OP_SET       = 3'd1;
    localparam logic [2:0] OP_PENALTY   = 3'd2;
    localparam logic [2:0] OP_QUERY     = 3'd3;
    localparam logic [2:0] OP_CLR_COUNT = 3'd4;
    localparam logic [2:0] OP_CLR_PEN   = 3'd5;

    localparam int COORD_WIDTH = 20;
    localparam int COUNT_WIDTH = 16;
    localparam int PEN_WIDTH = 20;
    localparam int SCORE_WIDTH = 21;
    localparam int INDEX_WIDTH = 12;

    localparam logic [2:0] REG_VOXEL_SIZE = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X   = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y   = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Z   = 3'd3;
    localparam logic [2:0] REG_CELLS_X    = 3'd4;
    localparam logic [2:0] REG_CELLS_Y    = 3'd5;
    localparam logic [2:0] REG_CELLS_Z    = 3'd6;
    localparam logic [2:0] REG_AXIS_COUNT = 3'd7;
endpackage

[rtl/vhh_ram.sv]
// generic single port ram with registered read
// no dependencies
module vhh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/voxel_hit_histogram_unit.sv]
// voxel hit histogram top level
// depends on vhh_pkg and vhh_ram
//
// One operation per input transaction, one result transaction each. Each of the
// two or three axes is quantized by a restoring divider that retires one quotient
// bit a cycle; an axis passes setup, the division, a range check and an index
// update in turn. An outside point stops after the axis whose range check puts it
// outside and at the end skips the modify and reread steps. The stores are single
// port rams, read, modified and written back in place. A clear operation sweeps its
// store at one entry a cycle. A new input transaction is taken only once the result
// has been taken, in the cycle after at the earliest. After reset both stores are
// swept once before the first item is accepted; configuration writes are taken
// throughout.
module voxel_hit_histogram_unit #(
    parameter int MAP_DEPTH   = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[2:0], pos_x, pos_y, pos_z, new_count, zero fill
    input  logic [(3+3*vhh_pkg::COORD_WIDTH+vhh_pkg::COUNT_WIDTH+7)/8*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // in_map, cell_index[11:0], hit_count, penalty[19:0], score_numerator[20:0],
    // max_count, zero fill
    output logic [(1+12+2*vhh_pkg::COUNT_WIDTH+20+21+7)/8*8-1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vhh_pkg::*;

    localparam int AW = $clog2(MAP_DEPTH);
    localparam int DW = COORD_WIDTH + 1;       // difference width
    localparam int CW = $clog2(DW + 1);
    localparam int OW = 1 + 12 + 2*COUNT_WIDTH + 20 + 21;
    localparam int OWP = (OW + 7) / 8 * 8;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
    localparam logic [PEN_WIDTH-1:0] PMAX = '1;
    localparam logic [AW:0] DEPTH_V = (AW+1)'(MAP_DEPTH);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DIVS  = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_AXIS  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_CLEAR = 4'd6;
    localparam logic [3:0] ST_READ  = 4'd7;
    localparam logic [3:0] ST_MOD   = 4'd8;
    localparam logic [3:0] ST_REREAD = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    // configuration
    logic [15:0] vsize_reg;
    logic [19:0] org_reg [3];
    logic [12:0] cells_reg [3];
    logic [1:0]  axes_reg;
    logic        wr_en;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vsize_reg <= 16'd1;
            org_reg[0] <= '0; org_reg[1] <= '0; org_reg[2] <= '0;
            cells_reg[0] <= 13'd16; cells_reg[1] <= 13'd16; cells_reg[2] <= 13'd16;
            axes_reg <= 2'd3;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_VOXEL_SIZE: vsize_reg <= pwdata[15:0];
                REG_ORIGIN_X:   org_reg[0] <= pwdata[19:0];
                REG_ORIGIN_Y:   org_reg[1] <= pwdata[19:0];
                REG_ORIGIN_Z:   org_reg[2] <= pwdata[19:0];
                REG_CELLS_X:    cells_reg[0] <= pwdata[12:0];
                REG_CELLS_Y:    cells_reg[1] <= pwdata[12:0];
                REG_CELLS_Z:    cells_reg[2] <= pwdata[12:0];
                REG_AXIS_COUNT: axes_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[4:2])
            REG_VOXEL_SIZE: prdata = {16'd0, vsize_reg};
            REG_ORIGIN_X:   prdata = {12'd0, org_reg[0]};
            REG_ORIGIN_Y:   prdata = {12'd0, org_reg[1]};
            REG_ORIGIN_Z:   prdata = {12'd0, org_reg[2]};
            REG_CELLS_X:    prdata = {19'd0, cells_reg[0]};
            REG_CELLS_Y:    prdata = {19'd0, cells_reg[1]};
            REG_CELLS_Z:    prdata = {19'd0, cells_reg[2]};
            default:        prdata = {30'd0, axes_reg};
        endcase
    end

    // item registers
    logic [3:0]  state_reg;
    logic [2:0]  op_reg;
    logic signed [COORD_WIDTH-1:0] pos_reg [3];
    logic [COUNT_WIDTH-1:0] newc_reg;
    logic [1:0]  axis_reg;
    logic        inside_reg;
    logic [AW:0] total_reg;
    logic [12:0] q_reg;      // per-axis quotient, zero when out of range
    logic [AW:0] sweep_reg;
    logic        clr_hit_reg, clr_pen_reg;
    logic [COUNT_WIDTH-1:0] max_reg;
    logic [OWP-1:0] out_reg;
    logic        mvalid_reg;

    // divider: magnitude of difference divided by voxel size
    logic        neg_reg;
    logic [DW-1:0] dq_reg;    // dividend shifting into quotient
    logic [16:0] rem_reg;
    logic [CW-1:0] dcnt_reg;
    logic [15:0] vs_eff;
    assign vs_eff = (vsize_reg == 16'd0) ? 16'd1 : vsize_reg;

    logic signed [DW-1:0] diff;
    logic [DW-1:0] mag;
    assign diff = DW'(pos_reg[axis_reg]) - DW'($signed(org_reg[axis_reg][COORD_WIDTH-1:0]));
    assign mag = diff[DW-1] ? DW'(-diff) : diff;

    logic [16:0] rem_sh, rem_sub;
    assign rem_sh = {rem_reg[15:0], dq_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, vs_eff};

    // floor of signed division: negative with remainder rounds one further
    logic [DW:0] qfloor;
    assign qfloor = neg_reg ? ((rem_reg != 17'd0) ? -({1'b0, dq_reg} + 1'b1)
                                                   : -{1'b0, dq_reg})
                            : {1'b0, dq_reg};

    logic [12:0] cells_cur;
    assign cells_cur = cells_reg[axis_reg];
    logic last_axis;
    assign last_axis = (axis_reg == 2'd2) || (axis_reg == 2'd1 && axes_reg == 2'd2);

    // rams
    logic hit_we, pen_we;
    logic [AW-1:0] addr;
    logic [COUNT_WIDTH-1:0] hit_wd, hit_rd;
    logic [PEN_WIDTH-1:0] pen_wd, pen_rd;
    vhh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAP_DEPTH)) u_hit_ram (
        .aclk(aclk), .we(hit_we), .addr(addr), .wdata(hit_wd), .rdata(hit_rd));
    vhh_ram #(.WIDTH(PEN_WIDTH), .DEPTH(MAP_DEPTH)) u_pen_ram (
        .aclk(aclk), .we(pen_we), .addr(addr), .wdata(pen_wd), .rdata(pen_rd));

    logic sweeping;
    assign sweeping = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign addr = sweeping ? sweep_reg[AW-1:0] : total_reg[AW-1:0];

    logic [COUNT_WIDTH-1:0] hit_mod;
    logic [PEN_WIDTH:0] pen_sum;
    logic [PEN_WIDTH-1:0] pen_mod;
    always_comb begin
        hit_mod = hit_rd;
        if (op_reg == OP_HIT) begin
            hit_mod = (hit_rd == CMAX) ? hit_rd : hit_rd + 1'b1;
        end else if (op_reg == OP_SET) begin
            hit_mod = newc_reg;
        end
    end
    assign pen_sum = {1'b0, pen_rd} + (PEN_WIDTH+1)'(max_reg);
    assign pen_mod = pen_sum[PEN_WIDTH] ? PMAX : pen_sum[PEN_WIDTH-1:0];

    assign hit_we = (sweeping && clr_hit_reg) ||
                    (state_reg == ST_MOD && (op_reg == OP_HIT || op_reg == OP_SET));
    assign pen_we = (sweeping && clr_pen_reg) ||
                    (state_reg == ST_MOD && op_reg == OP_PENALTY);
    assign hit_wd = sweeping ? '0 : hit_mod;
    assign pen_wd = sweeping ? '0 : pen_mod;

    logic signed [SCORE_WIDTH-1:0] score;
    assign score = SCORE_WIDTH'(hit_rd) - SCORE_WIDTH'(pen_rd);

    logic s_acc;
    assign s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
    assign s_acc = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata = out_reg;

    logic [AW:0] prod;
    assign prod = (AW+1)'(total_reg * cells_cur) + (AW+1)'(q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            sweep_reg <= '0;
            clr_hit_reg <= 1'b1;
            clr_pen_reg <= 1'b1;
            max_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) mvalid_reg <= 1'b0;
            case (state_reg)
                ST_INIT, ST_CLEAR: begin
                    if (sweep_reg == DEPTH_V - 1'b1) begin
                        sweep_reg <= '0;
                        state_reg <= (state_reg == ST_INIT) ? ST_IDLE : ST_READ;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        op_reg <= s_tdata[2:0];
                        pos_reg[0] <= s_tdata[3 +: COORD_WIDTH];
                        pos_reg[1] <= s_tdata[3+COORD_WIDTH +: COORD_WIDTH];
                        pos_reg[2] <= s_tdata[3+2*COORD_WIDTH +: COORD_WIDTH];
                        newc_reg <= s_tdata[3+3*COORD_WIDTH +: COUNT_WIDTH];
                        axis_reg <= 2'd0;
                        inside_reg <= 1'b1;
                        total_reg <= '0;
                        state_reg <= ST_DIVS;
                    end
                end
                ST_DIVS: begin
                    neg_reg <= diff[DW-1];
                    dq_reg <= mag;
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (rem_sub[16]) begin
                        rem_reg <= rem_sh;
                        dq_reg <= {dq_reg[DW-2:0], 1'b0};
                    end else begin
                        rem_reg <= rem_sub;
                        dq_reg <= {dq_reg[DW-2:0], 1'b1};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == CW'(DW - 1)) state_reg <= ST_AXIS;
                end
                ST_AXIS: begin
                    if (qfloor[DW] || (qfloor > (DW+1)'(13'h1FFF)) ||
                        (qfloor[12:0] >= cells_cur)) begin
                        inside_reg <= 1'b0;
                        q_reg <= '0;
                    end else begin
                        q_reg <= qfloor[12:0];
                    end
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // index stays below MAP_DEPTH while inside; full-width bound check
                    if (inside_reg) begin
                        if ((total_reg * cells_cur + q_reg) >= MAP_DEPTH) inside_reg <= 1'b0;
                        total_reg <= prod;
                    end
                    if (!inside_reg || last_axis) begin
                        if (op_reg == OP_CLR_COUNT || op_reg == OP_CLR_PEN) begin
                            clr_hit_reg <= (op_reg == OP_CLR_COUNT);
                            clr_pen_reg <= (op_reg == OP_CLR_PEN);
                            if (op_reg == OP_CLR_COUNT) max_reg <= '0;
                            state_reg <= ST_CLEAR;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end else begin
                        axis_reg <= axis_reg + 1'b1;
                        state_reg <= ST_DIVS;
                    end
                end
                ST_READ: begin
                    clr_hit_reg <= 1'b0;
                    clr_pen_reg <= 1'b0;
                    if (!inside_reg)
                        state_reg <= ST_OUT;
                    else if (op_reg != OP_CLR_COUNT && op_reg != OP_CLR_PEN)
                        state_reg <= ST_MOD;
                    else
                        state_reg <= ST_REREAD;
                end
                ST_MOD: begin
                    if (op_reg == OP_HIT || op_reg == OP_SET) begin
                        if (hit_mod > max_reg) max_reg <= hit_mod;
                    end
                    state_reg <= ST_REREAD;
                end
                ST_REREAD: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (inside_reg)
                        out_reg <= OWP'({max_reg, score, pen_rd, hit_rd,
                                         12'(total_reg), 1'b1});
                    else
                        out_reg <= OWP'({max_reg, 70'd0});
                    mvalid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

[rtl/voxel_hit_histogram_unit_checker.sv]
// port level checks of the voxel hit histogram
// depends on voxel_hit_histogram_unit_macros.svh
`include "voxel_hit_histogram_unit_macros.svh"
module voxel_hit_histogram_unit_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        pready
);
    `VHH_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `VHH_ASSERT_IMP(a_no_accept_pending, aclk, aresetn, m_tvalid, !s_tready, "input taken while result pending")
    `VHH_ASSERT_NEXT(a_no_result_after_accept, aclk, aresetn, s_tvalid && s_tready, !m_tvalid, "result came too early")
    `VHH_ASSERT_IMP(a_outside_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[69:1] == 69'd0, "outside point with data")
    `VHH_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready, "pready low")
endmodule

bind voxel_hit_histogram_unit voxel_hit_histogram_unit_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready));
